/* rtl/mstg_pkg.sv */
package mstg_pkg;

  localparam int unsigned CHANNELS_DEF = 3;
  localparam int unsigned LUT_BITS_DEF = 10;

  localparam int unsigned IDX_W = 32;
  localparam int unsigned FREQ_W = 32;
  localparam int unsigned PER_W = 24;
  localparam int unsigned CH_W = 4;
  localparam int unsigned TONE_W = 8;
  localparam int unsigned MAG_W = 7;
  localparam int unsigned REG_IDX_W = 2;

  localparam int unsigned FULL_SCALE = 100;
  localparam logic [PER_W-1:0] TREND_PERIOD_RST = 24'd5000;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FREQ_MIN     = 2'd0,
    REG_FREQ_MAX     = 2'd1,
    REG_FREQ_DELTA   = 2'd2,
    REG_TREND_PERIOD = 2'd3
  } reg_idx_t;

  // Trend segment number modulo three: falling, flat, rising frequency.
  typedef enum logic [1:0] {
    SEG_DOWN = 2'd0,
    SEG_FLAT = 2'd1,
    SEG_UP   = 2'd2
  } seg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    seg_t             seg;
  } seg_item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq_min;
    logic [FREQ_W-1:0] freq_delta;
    logic [FREQ_W-1:0] step;
  } tone_cfg_t;

  // Quotient modulo three after appending one more quotient bit.
  function automatic seg_t seg_next(seg_t s, logic b);
    seg_t r;
    case (s)
      SEG_DOWN: r = b ? SEG_FLAT : SEG_DOWN;
      SEG_FLAT: r = b ? SEG_DOWN : SEG_UP;
      SEG_UP:   r = b ? SEG_UP : SEG_FLAT;
      default:  r = SEG_DOWN;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // Long division used only while the sine table is built.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Magnitude of the sine in the first quadrant, 0 < r < quarter, from a
  // Taylor series in 60-bit fixed point, scaled by 100 and truncated.
  function automatic logic [MAG_W-1:0] quad_sine(int unsigned r, int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    logic [63:0] v;
    x = (PI_Q60 >> (bits - 1)) * 64'(r);
    x2 = mul_q60(x, x);
    term = x;
    sum = x;
    for (int n = 1; n <= 12; n++) begin
      den = 64'((2 * n) * (2 * n + 1));
      term = div_u64(mul_q60(term, x2), den);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = mul_q60(sum, 64'(FULL_SCALE) << 56) >> 56;
    if (v > 64'(FULL_SCALE)) begin
      v = 64'(FULL_SCALE);
    end
    return v[MAG_W-1:0];
  endfunction

endpackage

/* rtl/mstg_seg_div.sv */
module mstg_seg_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [mstg_pkg::IDX_W-1:0]   in_idx,
  input  logic [mstg_pkg::PER_W-1:0]   period,
  output logic                         out_valid,
  output mstg_pkg::seg_item_t          out_item
);
  import mstg_pkg::*;

  // Stage zero registers the incoming word, each later stage develops
  // one quotient bit of index / period and keeps the quotient modulo three.
  localparam int unsigned Stages = IDX_W + 1;

  logic             vld [Stages];
  logic [IDX_W-1:0] idx [Stages];
  logic [PER_W-1:0] rem [Stages];
  seg_t             seg [Stages];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx[0] <= in_idx;
      rem[0] <= '0;
      seg[0] <= SEG_DOWN;
    end
  end

  for (genvar k = 1; k < Stages; k++) begin : g_stage
    logic [PER_W:0] trial;
    logic [PER_W:0] diff;
    logic           ge;

    assign trial = {rem[k-1], idx[k-1][IDX_W-k]};
    assign diff  = trial - {1'b0, period};
    assign ge    = trial >= {1'b0, period};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        idx[k] <= idx[k-1];
        rem[k] <= ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
        seg[k] <= seg_next(seg[k-1], ge);
      end
    end
  end

  assign out_valid    = vld[Stages-1];
  assign out_item.idx = idx[Stages-1];
  assign out_item.seg = seg[Stages-1];

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !en |=> out_valid && $stable(out_item))
    else $error("divider output word changed while held");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rem[Stages-1] < period)
    else $error("final remainder not below the trend period");

endmodule

/* rtl/mstg_step_div.sv */
module mstg_step_div #(
  parameter int unsigned CHANNELS = mstg_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic [mstg_pkg::FREQ_W-1:0]   freq_min,
  input  logic [mstg_pkg::FREQ_W-1:0]   freq_max,
  output logic [mstg_pkg::FREQ_W-1:0]   step
);
  import mstg_pkg::*;

  // Division by the constant channel count minus one as a multiplication by
  // its rounded-up reciprocal, exact for every 32-bit magnitude. The step is
  // registered in the magnitude, product and step-word registers in turn.
  localparam int unsigned Div   = (CHANNELS > 1) ? CHANNELS - 1 : 1;
  localparam int unsigned Shift = FREQ_W + $clog2(Div);
  localparam int unsigned ProdW = 2 * FREQ_W + 1;
  localparam logic [FREQ_W:0] Recip =
    (FREQ_W+1)'(((64'd1 << Shift) + 64'(Div - 1)) / 64'(Div));

  logic              neg_p;
  logic [FREQ_W-1:0] mag_p;
  logic              neg_q;
  logic [ProdW-1:0]  prod;
  logic [FREQ_W-1:0] quot;
  logic [FREQ_W-1:0] step_word;

  always_ff @(posedge clk) begin
    neg_p <= freq_max < freq_min;
    mag_p <= (freq_max < freq_min) ? freq_min - freq_max : freq_max - freq_min;
  end

  always_ff @(posedge clk) begin
    neg_q <= neg_p;
    prod  <= ProdW'(mag_p) * ProdW'(Recip);
  end

  assign quot = FREQ_W'(prod >> Shift);

  always_ff @(posedge clk) begin
    step_word <= neg_q ? FREQ_W'(0) - quot : quot;
  end

  assign step = (CHANNELS > 1) ? step_word : '0;

endmodule

/* rtl/mstg_synth.sv */
module mstg_synth #(
  parameter int unsigned CHANNELS       = mstg_pkg::CHANNELS_DEF,
  parameter int unsigned PHASE_LUT_BITS = mstg_pkg::LUT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  mstg_pkg::seg_item_t                 in_item,
  output logic                                take,
  input  mstg_pkg::tone_cfg_t                 cfg,
  output logic                                tone_valid,
  input  logic                                tone_stall,
  output logic [mstg_pkg::CH_W-1:0]           channel,
  output logic signed [mstg_pkg::TONE_W-1:0]  tone_sample,
  output logic                                last
);
  import mstg_pkg::*;

  localparam int unsigned QW      = PHASE_LUT_BITS - 2;
  localparam int unsigned Quarter = 1 << QW;

  typedef logic [MAG_W-1:0] rom_t [Quarter];

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < Quarter; i++) begin
      t[i] = (i == 0) ? '0 : quad_sine(i, PHASE_LUT_BITS);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic                      adv;
  logic                      a_last;
  logic [FREQ_W-1:0]         load_word;
  logic [2*FREQ_W-1:0]       prod;
  logic [PHASE_LUT_BITS-1:0] addr;
  logic [1:0]                quad;
  logic [QW-1:0]             r;
  logic [QW-1:0]             ridx;
  logic [TONE_W-1:0]         mag_ext;

  logic              a_valid;
  logic [IDX_W-1:0]  a_idx;
  logic [FREQ_W-1:0] a_word;
  logic [CH_W-1:0]   a_ch;

  logic              b_valid;
  logic [FREQ_W-1:0] b_phase;
  logic [CH_W-1:0]   b_ch;
  logic              b_last;

  logic              c_valid;
  logic [MAG_W-1:0]  c_mag;
  logic              c_full;
  logic              c_neg;
  logic [CH_W-1:0]   c_ch;
  logic              c_last;

  assign adv    = !(c_valid && tone_stall);
  assign a_last = a_ch == CH_W'(CHANNELS - 1);
  assign take   = in_valid && (!a_valid || (a_last && adv));

  always_comb begin
    case (in_item.seg)
      SEG_DOWN: load_word = cfg.freq_min - cfg.freq_delta;
      SEG_UP:   load_word = cfg.freq_min + cfg.freq_delta;
      default:  load_word = cfg.freq_min;
    endcase
  end

  // Channel sequencer: one word per channel, frequency stepped by accumulation.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (adv && a_last) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_idx  <= in_item.idx;
      a_word <= load_word;
      a_ch   <= '0;
    end else if (adv && a_valid) begin
      a_word <= a_word + cfg.step;
      a_ch   <= a_ch + CH_W'(1);
    end
  end

  assign prod = a_word * a_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_phase <= prod[FREQ_W-1:0];
      b_ch    <= a_ch;
      b_last  <= a_last;
    end
  end

  // Quarter-wave table: odd quadrants read mirrored, the upper half negates.
  assign addr = b_phase[FREQ_W-1 -: PHASE_LUT_BITS];
  assign quad = addr[PHASE_LUT_BITS-1 -: 2];
  assign r    = addr[QW-1:0];
  assign ridx = quad[0] ? QW'(0) - r : r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_mag  <= SINE_ROM[ridx];
      c_full <= quad[0] && (r == '0);
      c_neg  <= quad[1];
      c_ch   <= b_ch;
      c_last <= b_last;
    end
  end

  assign mag_ext     = c_full ? TONE_W'(FULL_SCALE) : TONE_W'(c_mag);
  assign tone_sample = $signed(c_neg ? TONE_W'(0) - mag_ext : mag_ext);
  assign tone_valid  = c_valid;
  assign channel     = c_ch;
  assign last        = c_last;

  assert property (@(posedge clk) disable iff (rst)
    tone_valid && !tone_stall && !last |=>
      tone_valid && (channel == $past(channel) + CH_W'(1)))
    else $error("channel words of one index not back to back");

  assert property (@(posedge clk) disable iff (rst)
    take |=> a_valid && (a_ch == '0))
    else $error("sequencer did not restart at channel zero");

  assert property (@(posedge clk) disable iff (rst)
    c_valid |-> c_mag <= MAG_W'(FULL_SCALE))
    else $error("sine magnitude above full scale");

endmodule

/* rtl/multichannel_stepped_tone_generator.sv */
// An accepted index word runs through the divider stages, then the sequencer,
// phase and table registers, to its channel 0 word. Result words leave one per
// cycle while tone_stall is low; the sequencer walks one index's channels in
// order, taking the next index on the last. Reset (synchronous, active high)
// empties the pipeline and loads zero frequencies and a trend period of 5000.
module multichannel_stepped_tone_generator #(
  parameter int unsigned CHANNELS       = mstg_pkg::CHANNELS_DEF,
  parameter int unsigned PHASE_LUT_BITS = mstg_pkg::LUT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [mstg_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [mstg_pkg::FREQ_W-1:0]         cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [mstg_pkg::IDX_W-1:0]          sample_index,
  output logic                                tone_valid,
  input  logic                                tone_stall,
  output logic [mstg_pkg::CH_W-1:0]           channel,
  output logic signed [mstg_pkg::TONE_W-1:0]  tone_sample,
  output logic                                last
);
  import mstg_pkg::*;

  logic [FREQ_W-1:0] freq_min;
  logic [FREQ_W-1:0] freq_max;
  logic [FREQ_W-1:0] freq_delta;
  logic [PER_W-1:0]  trend_period;

  logic              div_en;
  logic              div_valid;
  seg_item_t         div_item;
  logic              take;
  logic [FREQ_W-1:0] step;
  tone_cfg_t         tone_cfg;

  // A zero trend period is stored as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      freq_min     <= '0;
      freq_max     <= '0;
      freq_delta   <= '0;
      trend_period <= TREND_PERIOD_RST;
    end else if (cfg_write_en) begin
      case (reg_idx_t'(cfg_index))
        REG_FREQ_MIN:     freq_min   <= cfg_data;
        REG_FREQ_MAX:     freq_max   <= cfg_data;
        REG_FREQ_DELTA:   freq_delta <= cfg_data;
        REG_TREND_PERIOD: begin
          trend_period <= (cfg_data[PER_W-1:0] == '0) ? PER_W'(1) : cfg_data[PER_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign div_en       = !div_valid || take;
  assign sample_stall = !div_en;

  mstg_seg_div u_seg_div (
    .clk       (clk),
    .rst       (rst),
    .en        (div_en),
    .in_valid  (sample_valid),
    .in_idx    (sample_index),
    .period    (trend_period),
    .out_valid (div_valid),
    .out_item  (div_item)
  );

  mstg_step_div #(
    .CHANNELS (CHANNELS)
  ) u_step_div (
    .clk      (clk),
    .freq_min (freq_min),
    .freq_max (freq_max),
    .step     (step)
  );

  assign tone_cfg.freq_min   = freq_min;
  assign tone_cfg.freq_delta = freq_delta;
  assign tone_cfg.step       = step;

  mstg_synth #(
    .CHANNELS       (CHANNELS),
    .PHASE_LUT_BITS (PHASE_LUT_BITS)
  ) u_synth (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (div_valid),
    .in_item     (div_item),
    .take        (take),
    .cfg         (tone_cfg),
    .tone_valid  (tone_valid),
    .tone_stall  (tone_stall),
    .channel     (channel),
    .tone_sample (tone_sample),
    .last        (last)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import mstg_pkg::*;

  localparam int unsigned CHANNELS    = 3;
  localparam int unsigned LUT_BITS    = 10;
  localparam int unsigned LUT_SIZE    = 1 << LUT_BITS;
  localparam int unsigned LATENCY     = 36;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [63:0] PI_FIX60    = 64'h3243_F6A8_885A_308D;

  typedef struct {
    logic [IDX_W-1:0]         idx;
    logic [CH_W-1:0]          ch;
    logic signed [TONE_W-1:0] tone;
    logic                     lst;
  } tone_word_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     cfg_write_en = 1'b0;
  logic [REG_IDX_W-1:0]     cfg_index = '0;
  logic [FREQ_W-1:0]        cfg_data = '0;
  logic                     sample_valid = 1'b0;
  logic                     sample_stall;
  logic [IDX_W-1:0]         sample_index = '0;
  logic                     tone_valid;
  logic                     tone_stall = 1'b0;
  logic [CH_W-1:0]          channel;
  logic signed [TONE_W-1:0] tone_sample;
  logic                     last;

  logic [FREQ_W-1:0]        cfg_freq_min = '0;
  logic [FREQ_W-1:0]        cfg_freq_max = '0;
  logic [FREQ_W-1:0]        cfg_freq_delta = '0;
  logic [PER_W-1:0]         cfg_trend_period = 24'd5000;

  logic signed [TONE_W-1:0] sine_rom [LUT_SIZE];
  tone_word_t               pending_tones [$];
  int                       mismatch_count = 0;
  int                       hold_request = 0;
  bit                       idle_off = 1'b0;

  multichannel_stepped_tone_generator #(
    .CHANNELS(CHANNELS),
    .PHASE_LUT_BITS(LUT_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_index(sample_index),
    .tone_valid(tone_valid),
    .tone_stall(tone_stall),
    .channel(channel),
    .tone_sample(tone_sample),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> 60);
  endfunction

  // The table holds trunc(100*sin) per phase address, built from a Taylor
  // series in 60-bit fixed point and exact at the quadrant points.
  initial begin : sine_rom_init
    int unsigned quarter;
    int unsigned q;
    int unsigned r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    logic [63:0] v;
    int mag;
    quarter = 1 << (LUT_BITS - 2);
    for (int a = 0; a < LUT_SIZE; a++) begin
      q = (a >> (LUT_BITS - 2)) & 3;
      r = a & (quarter - 1);
      if (q & 1) begin
        r = quarter - r;
      end
      if (r == 0) begin
        mag = 0;
      end else if (r == quarter) begin
        mag = 100;
      end else begin
        x = (PI_FIX60 >> (LUT_BITS - 1)) * 64'(r);
        x2 = q60_mul(x, x);
        term = x;
        sum = x;
        for (int n = 1; n <= 12; n++) begin
          den = 64'((2 * n) * (2 * n + 1));
          term = q60_mul(term, x2) / den;
          if (n % 2 == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        v = q60_mul(sum, 64'd100 << 56) >> 56;
        if (v > 64'd100) begin
          v = 64'd100;
        end
        mag = int'(v);
      end
      sine_rom[a] = 8'((q >= 2) ? -mag : mag);
    end
  end

  function automatic void predict_tones(logic [IDX_W-1:0] idx);
    logic [31:0] per;
    logic [31:0] offset;
    logic [31:0] word;
    logic [31:0] phase;
    logic [63:0] acc;
    longint      span;
    longint      stride;
    seg_t        seg;
    tone_word_t  w;
    per = (cfg_trend_period == '0) ? 32'd1 : 32'(cfg_trend_period);
    seg = seg_t'((idx / per) % 3);
    case (seg)
      SEG_DOWN: offset = -cfg_freq_delta;
      SEG_FLAT: offset = '0;
      default:  offset = cfg_freq_delta;
    endcase
    stride = 0;
    if (CHANNELS > 1) begin
      span = longint'({32'd0, cfg_freq_max}) - longint'({32'd0, cfg_freq_min});
      stride = span / longint'(CHANNELS - 1);
    end
    for (int ch = 0; ch < CHANNELS; ch++) begin
      acc = {32'd0, cfg_freq_min} + 64'(stride) * 64'(ch) + {32'd0, offset};
      word = acc[31:0];
      phase = word * idx;
      w.idx = idx;
      w.ch = CH_W'(ch);
      w.tone = sine_rom[phase >> (32 - LUT_BITS)];
      w.lst = (ch == CHANNELS - 1);
      pending_tones.push_back(w);
    end
  endfunction

  task automatic flag_tone_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  initial begin : tone_checker
    tone_word_t w;
    forever begin
      @(posedge clk);
      if (tone_valid === 1'b1 && tone_stall == 1'b0) begin
        if (pending_tones.size() == 0) begin
          flag_tone_error($sformatf("unexpected word, channel %0d tone %0d",
                                    channel, tone_sample));
        end else begin
          w = pending_tones.pop_front();
          if (channel !== w.ch) begin
            flag_tone_error($sformatf("index %h: channel %0d, expected %0d",
                                      w.idx, channel, w.ch));
          end
          if (tone_sample !== w.tone) begin
            flag_tone_error($sformatf("index %h channel %0d: tone %0d, expected %0d",
                                      w.idx, w.ch, tone_sample, w.tone));
          end
          if (last !== w.lst) begin
            flag_tone_error($sformatf("index %h channel %0d: last %b, expected %b",
                                      w.idx, w.ch, last, w.lst));
          end
        end
      end
    end
  end

  initial begin : tone_stall_gen
    int burst;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        tone_stall <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
        tone_stall <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8);
        tone_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        tone_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int dead_cycles;
    dead_cycles = 0;
    forever begin
      @(posedge clk);
      if ((sample_valid && sample_stall === 1'b0) || (tone_valid === 1'b1 && !tone_stall)) begin
        dead_cycles = 0;
      end else begin
        dead_cycles++;
      end
      if (dead_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Leaves valid high on return; the caller sends the next word or drains
  // in the same time step.
  task automatic send_index(input logic [IDX_W-1:0] idx);
    int gap;
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_index <= idx;
    do @(posedge clk); while (sample_stall !== 1'b0);
    predict_tones(idx);
  endtask

  task automatic drain_tones(input int settle);
    sample_valid <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] fmin, input logic [31:0] fmax,
                             input logic [31:0] fdelta, input logic [31:0] period_word);
    drain_tones(4);
    cfg_write_en <= 1'b1;
    cfg_index <= REG_FREQ_MIN;
    cfg_data <= fmin;
    @(posedge clk);
    cfg_index <= REG_FREQ_MAX;
    cfg_data <= fmax;
    @(posedge clk);
    cfg_index <= REG_FREQ_DELTA;
    cfg_data <= fdelta;
    @(posedge clk);
    cfg_index <= REG_TREND_PERIOD;
    cfg_data <= period_word;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cfg_freq_min = fmin;
    cfg_freq_max = fmax;
    cfg_freq_delta = fdelta;
    cfg_trend_period = period_word[PER_W-1:0];
  endtask

  function automatic logic [31:0] pick_index();
    logic [31:0] per;
    per = (cfg_trend_period == '0) ? 32'd1 : 32'(cfg_trend_period);
    case ($urandom_range(0, 3))
      0:       return 32'($urandom_range(0, 255));
      1:       return per * $urandom_range(0, 1000) + $urandom_range(0, 2) - 32'd1;
      2:       return {24'hFF_FFFF, 8'($urandom_range(0, 255))};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_freq();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'($urandom_range(0, 32'h00FF_FFFF));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_period_word();
    case ($urandom_range(0, 5))
      0:       return {8'($urandom()), 24'd0};
      1:       return {8'($urandom()), 24'd1};
      2:       return {8'($urandom()), 24'hFF_FFFF};
      3:       return {8'($urandom()), 24'($urandom())};
      default: return 32'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic test_reset_values();
    logic [31:0] idx_list [4] = '{32'd0, 32'hFFFF_FFFF, 32'd5000, 32'd10000};
    foreach (idx_list[i]) send_index(idx_list[i]);
  endtask

  task automatic test_quadrant_points();
    logic [31:0] idx_list [4] = '{32'd0, 32'd1, 32'd2, 32'd3};
    load_config(32'h4000_0000, 32'h4000_0000, 32'd0, 32'd5000);
    foreach (idx_list[i]) send_index(idx_list[i]);
  endtask

  task automatic test_frequency_extremes();
    logic [31:0] idx_list [3] = '{32'hFFFF_FFFF, 32'h00FF_FFFE, 32'h8000_0001};
    load_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    foreach (idx_list[i]) send_index(idx_list[i]);
  endtask

  // A falling channel step, and a trend period of zero that acts as one.
  task automatic test_descending_zero_period();
    logic [31:0] idx_list [4] = '{32'd1, 32'd2, 32'd3, 32'hAAAA_AAAA};
    load_config(32'hFFFF_FFFF, 32'd0, 32'h1234_5678, 32'hAB00_0000);
    foreach (idx_list[i]) send_index(idx_list[i]);
  endtask

  task automatic test_trend_segments();
    logic [31:0] idx_list [6] = '{32'd4, 32'd5, 32'd9, 32'd10, 32'd14, 32'd15};
    load_config(32'h0100_0000, 32'h0300_0000, 32'h0040_0000, 32'd5);
    foreach (idx_list[i]) send_index(idx_list[i]);
  endtask

  task automatic test_random_configs();
    repeat (5) begin
      load_config(pick_freq(), pick_freq(), pick_freq(), pick_period_word());
      repeat (40) send_index(pick_index());
    end
  endtask

  task automatic test_output_backpressure();
    load_config($urandom(), $urandom(), pick_freq(), pick_period_word());
    hold_request = HOLD_CYCLES;
    repeat (60) send_index(pick_index());
  endtask

  task automatic test_steady_stream();
    load_config(pick_freq(), pick_freq(), $urandom(), pick_period_word());
    idle_off = 1'b1;
    repeat (30) send_index(pick_index());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_quadrant_points();
    test_frequency_extremes();
    test_descending_zero_period();
    test_trend_segments();
    test_random_configs();
    test_output_backpressure();
    test_steady_stream();
    drain_tones(LATENCY + 14);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mstg_pkg.sv
rtl/mstg_seg_div.sv
rtl/mstg_step_div.sv
rtl/mstg_synth.sv
rtl/multichannel_stepped_tone_generator.sv
tb/sv/testbench.sv
